/* rtl/lmmf_pkg.sv */
package lmmf_pkg;

  localparam int SAMPLE_WIDTH    = 16;
  localparam int CFG_WIDTH       = 4;
  localparam int CFG_INDEX_WIDTH = 2;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_KERNEL_SIZE = 2'd0,
    CFG_PAD_MODE    = 2'd1,
    CFG_FILTER_MODE = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic                           last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] filtered_sample;
    logic                           last_out;
  } out_item_t;

endpackage

/* rtl/line_median_mean_filter_core.sv */
// Sliding-window median or mean filter over lines of signed samples. Every input
// transaction shifts one sample into the window store and then produces zero or more
// output transactions: one as soon as the window to the right of a position is full,
// and on the sample marked last, all positions still pending. The block handles one
// input sample at a time and holds in_stall high while it works on it, stepping through
// the window positions it considers in turn. A median output fills a window of K taps;
// then a single comparator counts the samples below and equal to one candidate at a
// time, ranking the candidates in turn until one is the median, which is emitted. A mean
// output fills the window and its sum, takes one setup step and 20 steps of a bit-serial
// restoring divider at the default sizes, and emits the quotient. A finished output
// waits in the output register without holding up further work until the next result
// is ready. Configuration writes are taken at any time and must only happen while the
// block is idle.
module line_median_mean_filter_core #(
  parameter int MAX_KERNEL = 15
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_enable,
  input  logic [lmmf_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [lmmf_pkg::CFG_WIDTH-1:0]       cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  lmmf_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output lmmf_pkg::out_item_t                 out_item
);
  import lmmf_pkg::*;

  localparam int KW  = $clog2(MAX_KERNEL + 1);
  localparam int IW  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int SW  = SAMPLE_WIDTH + KW;
  localparam int DCW = $clog2(SW + 1);

  typedef enum logic [3:0] {
    IDLE,
    PAD,
    CHECK,
    FILL,
    DIV_SETUP,
    DIVIDE,
    SEL_LOAD,
    SEL_CMP,
    SEL_CHECK,
    EMIT
  } state_t;

  state_t state;

  logic [CFG_WIDTH-1:0] kernel_size;
  logic                 pad_mode;
  logic                 filter_mode;

  logic signed [SAMPLE_WIDTH-1:0] store [MAX_KERNEL];
  logic signed [SAMPLE_WIDTH-1:0] win   [MAX_KERNEL];
  logic [KW-1:0]                  seen_count;
  logic                           line_open;

  logic [KW-1:0]                  seen;
  logic                           last;
  logic signed [SAMPLE_WIDTH-1:0] newest;
  logic signed [SAMPLE_WIDTH-1:0] oldest;
  logic [KW-1:0]                  t;
  logic [KW-1:0]                  i;
  logic [KW-1:0]                  j;
  logic [KW-1:0]                  cand_idx;
  logic signed [SAMPLE_WIDTH-1:0] cand;
  logic [KW-1:0]                  less;
  logic [KW-1:0]                  equal;
  logic signed [SW-1:0]           sum;
  logic                           neg;
  logic [SW-1:0]                  quo;
  logic [KW:0]                    rem;
  logic [DCW-1:0]                 div_count;
  logic signed [SAMPLE_WIDTH-1:0] result;

  logic [KW-1:0]                  k_eff;
  logic [KW-1:0]                  k_m1;
  logic [KW-1:0]                  left;
  logic [KW-1:0]                  right;
  logic [KW-1:0]                  tmax;
  logic [KW-1:0]                  seen_prev;
  logic [KW-1:0]                  seen_next;
  logic [KW-1:0]                  seen_m1;
  logic [KW:0]                    offset;
  logic [KW-1:0]                  tap_dist;
  logic signed [SAMPLE_WIDTH-1:0] tap_value;
  logic signed [SW-1:0]           sum_next;
  logic [KW-1:0]                  win_addr;
  logic signed [SAMPLE_WIDTH-1:0] win_data;
  logic [KW:0]                    trial;
  logic                           trial_ge;
  logic [KW:0]                    less_equal;
  logic [SAMPLE_WIDTH-1:0]        quo_low;
  logic                           out_free;
  logic                           in_accept;

  assign in_stall  = (state != IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    if (kernel_size == '0) begin
      k_eff = KW'(1);
    end else if (int'(kernel_size) > MAX_KERNEL) begin
      k_eff = KW'(MAX_KERNEL);
    end else begin
      k_eff = KW'(kernel_size);
    end
  end

  assign k_m1  = k_eff - KW'(1);
  assign left  = k_eff >> 1;
  assign right = k_m1 - left;
  assign tmax  = last ? right : '0;

  always_comb begin
    seen_prev = line_open ? seen_count : '0;
    if (seen_prev > k_eff) begin
      seen_prev = k_eff;
    end
    seen_next = (seen_prev < k_eff) ? seen_prev + KW'(1) : seen_prev;
  end

  assign seen_m1 = seen - KW'(1);

  assign offset   = {1'b0, t} + {1'b0, i};
  assign tap_dist = k_m1 - offset[KW-1:0];

  always_comb begin
    if (offset > {1'b0, k_m1}) begin
      tap_value = pad_mode ? newest : '0;
    end else if (tap_dist >= seen) begin
      tap_value = pad_mode ? oldest : '0;
    end else begin
      tap_value = store[tap_dist[IW-1:0]];
    end
  end

  assign sum_next = sum + {{KW{tap_value[SAMPLE_WIDTH-1]}}, tap_value};

  assign win_addr = (state == SEL_LOAD) ? cand_idx : j;
  assign win_data = win[win_addr[IW-1:0]];

  assign trial    = {rem[KW-1:0], quo[SW-1]};
  assign trial_ge = trial >= {1'b0, k_eff};

  assign less_equal = {1'b0, less} + {1'b0, equal};
  assign quo_low    = quo[SAMPLE_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      kernel_size <= CFG_WIDTH'(3);
      pad_mode    <= 1'b0;
      filter_mode <= 1'b0;
      seen_count  <= '0;
      line_open   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_write_enable) begin
        case (cfg_index)
          CFG_KERNEL_SIZE: kernel_size <= cfg_data;
          CFG_PAD_MODE:    pad_mode    <= cfg_data[0];
          CFG_FILTER_MODE: filter_mode <= cfg_data[0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall && state != EMIT) begin
        out_valid <= 1'b0;
      end

      case (state)
        IDLE: begin
          if (in_accept) begin
            store[0] <= in_item.sample_in;
            for (int n = 1; n < MAX_KERNEL; n++) begin
              store[n] <= store[n-1];
            end
            newest     <= in_item.sample_in;
            last       <= in_item.last_in;
            seen       <= seen_next;
            seen_count <= in_item.last_in ? '0 : seen_next;
            line_open  <= !in_item.last_in;
            t          <= '0;
            state      <= PAD;
          end
        end
        PAD: begin
          oldest <= store[seen_m1[IW-1:0]];
          state  <= CHECK;
        end
        CHECK: begin
          if (t > tmax) begin
            state <= IDLE;
          end else if (({1'b0, t} + {1'b0, seen}) <= {1'b0, right}) begin
            t <= t + KW'(1);
          end else begin
            i     <= '0;
            sum   <= '0;
            state <= FILL;
          end
        end
        FILL: begin
          win[i[IW-1:0]] <= tap_value;
          sum            <= sum_next;
          i              <= i + KW'(1);
          if (i == k_m1) begin
            cand_idx <= '0;
            state    <= filter_mode ? DIV_SETUP : SEL_LOAD;
          end
        end
        DIV_SETUP: begin
          neg       <= sum[SW-1];
          quo       <= sum[SW-1] ? SW'(-sum) : SW'(sum);
          rem       <= '0;
          div_count <= '0;
          state     <= DIVIDE;
        end
        DIVIDE: begin
          rem       <= trial_ge ? trial - {1'b0, k_eff} : trial;
          quo       <= {quo[SW-2:0], trial_ge};
          div_count <= div_count + DCW'(1);
          if (div_count == DCW'(SW - 1)) begin
            state <= EMIT;
          end
        end
        SEL_LOAD: begin
          cand  <= win_data;
          j     <= '0;
          less  <= '0;
          equal <= '0;
          state <= SEL_CMP;
        end
        SEL_CMP: begin
          if (win_data < cand) begin
            less <= less + KW'(1);
          end else if (win_data == cand) begin
            equal <= equal + KW'(1);
          end
          j <= j + KW'(1);
          if (j == k_m1) begin
            state <= SEL_CHECK;
          end
        end
        SEL_CHECK: begin
          if ((less <= left && {1'b0, left} < less_equal) || cand_idx == k_m1) begin
            result <= cand;
            state  <= EMIT;
          end else begin
            cand_idx <= cand_idx + KW'(1);
            state    <= SEL_LOAD;
          end
        end
        EMIT: begin
          if (out_free) begin
            out_valid                <= 1'b1;
            out_item.filtered_sample <= filter_mode ?
                                        (neg ? -quo_low : quo_low) : result;
            out_item.last_out        <= last && (t == tmax);
            t                        <= t + KW'(1);
            state                    <= CHECK;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
